// ----- hdl/dedf_pkg.sv -----
// ----------------------------------------------------------------------------
// dedf_pkg: shared types and helpers for the entry field deframer
// Phase codes, register indexes, the result item layout and the small
// functions used by the configuration, core and result queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dedf_pkg;

  // Number of listed field types that can be in use
  localparam int MAX_SEQUENCE = 8;
  // Width of a decoded field length
  localparam int LENGTH_BITS  = 32;
  // Slot index into the 8-entry type list
  localparam int SLOT_BITS    = 3;
  localparam int COUNT_BITS   = 32;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [SLOT_BITS-1:0]   SLOT_TOP = '1;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_TEXT = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_ALL  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_TYPES = 2'd1,
    REG_COUNT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                 seq_mode;
    logic [63:0]          type_seq;
    logic [SLOT_BITS-1:0] last_slot;
  } cfg_t;

  typedef struct packed {
    logic [7:0]            field_type;
    logic [7:0]            payload_byte;
    logic                  payload_valid;
    logic                  field_done;
    logic [COUNT_BITS-1:0] field_bytes;
    logic                  error_flag;
    logic                  entry_done;
    logic                  last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [7:0] slot_type(input logic [63:0] seq,
                                           input logic [SLOT_BITS-1:0] idx);
    return seq[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic is_lower(input logic [7:0] t);
    return (t >= 8'h61) && (t <= 8'h7a);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic result_t make_result(input logic [7:0] t, input logic [7:0] b,
                                          input logic pv, input logic fd,
                                          input logic [COUNT_BITS-1:0] fb);
    result_t r;
    r               = '0;
    r.field_type    = t;
    r.payload_byte  = b;
    r.payload_valid = pv;
    r.field_done    = fd;
    r.field_bytes   = fb;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dedf_cfg.sv -----
// ----------------------------------------------------------------------------
// dedf_cfg: configuration registers
// Holds the mode, the type list and the list length, and derives the index
// of the final used slot from the clamped list length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dedf_cfg
  import dedf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output cfg_t             cfg
);

  logic        sequence_mode;
  logic [63:0] type_sequence;
  logic [3:0]  sequence_count;

  assign cfg_ready = 1'b1;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_mode  <= 1'b0;
      type_sequence  <= '0;
      sequence_count <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:  sequence_mode  <= cfg_data[0];
        REG_TYPES: type_sequence  <= cfg_data;
        REG_COUNT: sequence_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the list length to 1..MAX_SEQUENCE and give the final slot
  always_comb begin
    cfg.seq_mode = sequence_mode;
    cfg.type_seq = type_sequence;
    if (sequence_count == 4'd0) begin
      cfg.last_slot = '0;
    end else if (sequence_count > 4'(MAX_SEQUENCE)) begin
      cfg.last_slot = SLOT_BITS'(MAX_SEQUENCE - 1);
    end else begin
      cfg.last_slot = SLOT_BITS'(sequence_count - 4'd1);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dedf_core.sv -----
// ----------------------------------------------------------------------------
// dedf_core: input register and per-byte field decoder
// Registers one input item, decodes it against the entry state in a single
// pass and hands zero, one or two result items to the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dedf_core
  import dedf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic [1:0] free,
  output push_t           push
);

  // Input register
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;
  logic       advance;

  // Entry state
  phase_t                 phase,              phase_next;
  logic [7:0]             current_type,       current_type_next;
  logic [1:0]             header_index,       header_index_next;
  logic [31:0]            length_accumulator, length_accumulator_next;
  logic [LENGTH_BITS-1:0] bytes_remaining,    bytes_remaining_next;
  logic [COUNT_BITS-1:0]  content_count,      content_count_next;
  logic [SLOT_BITS-1:0]   sequence_index,     sequence_index_next;
  logic                   error_seen,         error_seen_next;

  // Decode working signals
  logic                 start;
  logic                 consumed;
  logic                 open_final;
  logic [7:0]           open_type;
  logic [SLOT_BITS-1:0] slot_a;
  logic [SLOT_BITS-1:0] slot_b;
  logic                 len_over;
  logic [1:0]           n;
  result_t              r0;
  result_t              r1;
  result_t              tail;

  assign advance  = q_valid && (n <= free);
  assign in_stall = q_valid && !advance;

  // Hold the item until the decoder takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_byte <= data_byte;
      q_last <= last_byte;
    end
  end

  // Decode one byte against the entry state
  always_comb begin
    phase_next              = phase;
    current_type_next       = current_type;
    header_index_next       = header_index;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    content_count_next      = content_count;
    sequence_index_next     = sequence_index;
    error_seen_next         = error_seen;
    consumed                = 1'b0;
    open_final              = 1'b0;
    open_type               = q_byte;
    len_over                = 1'b0;
    slot_b                  = '0;
    tail                    = '0;
    n                       = 2'd0;
    r0                      = '0;
    r1                      = '0;

    start  = (phase != PH_TEXT) && (phase != PH_LEN) && (phase != PH_DATA) &&
             (phase != PH_ALL);
    slot_a = (sequence_index > cfg.last_slot) ? cfg.last_slot : sequence_index;

    // Open a new field, type from the list or from the stream
    if (start) begin
      if (cfg.seq_mode) begin
        open_type  = slot_type(cfg.type_seq, slot_a);
        open_final = (slot_a == cfg.last_slot);
      end else begin
        consumed = 1'b1;
      end
      current_type_next       = open_type;
      header_index_next       = '0;
      length_accumulator_next = '0;
      bytes_remaining_next    = '0;
      content_count_next      = '0;
      if (open_final) begin
        phase_next = PH_ALL;
      end else if (is_lower(open_type)) begin
        phase_next = PH_TEXT;
      end else begin
        phase_next = PH_LEN;
      end
    end

    // Advance the open field by this byte
    if (!consumed) begin
      case (phase_next)
        PH_TEXT: begin
          if (q_byte == 8'd0) begin
            r0 = make_result(current_type_next, 8'd0, 1'b0, 1'b1, content_count_next);
            n  = 2'd1;
            phase_next = PH_TYPE;
            if (sequence_index_next != SLOT_TOP) begin
              sequence_index_next = sequence_index_next + SLOT_BITS'(1);
            end
          end else begin
            r0 = make_result(current_type_next, q_byte, 1'b1, 1'b0, '0);
            n  = 2'd1;
            content_count_next = sat_inc(content_count_next);
          end
        end
        PH_LEN: begin
          length_accumulator_next = {length_accumulator_next[23:0], q_byte};
          header_index_next       = header_index_next + 2'd1;
          if (header_index_next == 2'd0) begin
            len_over = (({1'b0, length_accumulator_next} >> LENGTH_BITS) != 33'd0);
            if (len_over) begin
              bytes_remaining_next = LEN_MAX;
              error_seen_next      = 1'b1;
            end else begin
              bytes_remaining_next = length_accumulator_next[LENGTH_BITS-1:0];
            end
            if (bytes_remaining_next == '0) begin
              r0 = make_result(current_type_next, 8'd0, 1'b0, 1'b1, '0);
              n  = 2'd1;
              phase_next = PH_TYPE;
              if (sequence_index_next != SLOT_TOP) begin
                sequence_index_next = sequence_index_next + SLOT_BITS'(1);
              end
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          content_count_next   = sat_inc(content_count_next);
          bytes_remaining_next = bytes_remaining_next - LENGTH_BITS'(1);
          n = 2'd1;
          if (bytes_remaining_next == '0) begin
            r0 = make_result(current_type_next, q_byte, 1'b1, 1'b1, content_count_next);
            phase_next = PH_TYPE;
            if (sequence_index_next != SLOT_TOP) begin
              sequence_index_next = sequence_index_next + SLOT_BITS'(1);
            end
          end else begin
            r0 = make_result(current_type_next, q_byte, 1'b1, 1'b0, '0);
          end
        end
        default: begin
          content_count_next = sat_inc(content_count_next);
          r0 = make_result(current_type_next, q_byte, 1'b1, 1'b0, '0);
          n  = 2'd1;
        end
      endcase
    end

    // Close the entry on its final byte
    if (q_last) begin
      if (phase_next == PH_ALL) begin
        r0.field_done  = 1'b1;
        r0.field_bytes = content_count_next;
      end else if (phase_next == PH_TYPE) begin
        if (cfg.seq_mode) begin
          slot_b = (sequence_index_next > cfg.last_slot) ? cfg.last_slot :
                   sequence_index_next;
          if (slot_b == cfg.last_slot) begin
            tail = make_result(slot_type(cfg.type_seq, slot_b), 8'd0, 1'b0, 1'b1, '0);
          end else begin
            error_seen_next = 1'b1;
            tail = make_result(slot_type(cfg.type_seq, slot_b), 8'd0, 1'b0, 1'b0, '0);
          end
          if (n == 2'd0) begin
            r0 = tail;
            n  = 2'd1;
          end else begin
            r1 = tail;
            n  = 2'd2;
          end
        end
      end else begin
        error_seen_next = 1'b1;
      end
      if (n == 2'd0) begin
        r0 = make_result(current_type_next, 8'd0, 1'b0, 1'b0, '0);
        n  = 2'd1;
      end
      if (n == 2'd2) begin
        r1.error_flag = error_seen_next;
        r1.entry_done = 1'b1;
      end else begin
        r0.error_flag = error_seen_next;
        r0.entry_done = 1'b1;
      end
      // Return all entry state to reset
      phase_next              = PH_TYPE;
      current_type_next       = '0;
      header_index_next       = '0;
      length_accumulator_next = '0;
      bytes_remaining_next    = '0;
      content_count_next      = '0;
      sequence_index_next     = '0;
      error_seen_next         = 1'b0;
    end

    // Mark the last result of this item
    if (n == 2'd2) begin
      r1.last_result = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_result = 1'b1;
    end
  end

  // Push results only when the item is taken
  always_comb begin
    push.count = advance ? n : 2'd0;
    push.r0    = r0;
    push.r1    = r1;
  end

  // Update entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TYPE;
      current_type       <= '0;
      header_index       <= '0;
      length_accumulator <= '0;
      bytes_remaining    <= '0;
      content_count      <= '0;
      sequence_index     <= '0;
      error_seen         <= 1'b0;
    end else if (advance) begin
      phase              <= phase_next;
      current_type       <= current_type_next;
      header_index       <= header_index_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
      content_count      <= content_count_next;
      sequence_index     <= sequence_index_next;
      error_seen         <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dedf_outq.sv -----
// ----------------------------------------------------------------------------
// dedf_outq: two-entry result queue
// Takes up to two result items per cycle from the decoder and presents one
// registered item at a time on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dedf_outq
  import dedf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic [1:0] free,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    head
);

  logic [1:0] count;
  logic [1:0] count_after;
  logic       pop;
  result_t    slot0, slot0_next;
  result_t    slot1, slot1_next;

  assign out_valid   = (count != 2'd0);
  assign pop         = out_valid && !out_stall;
  assign count_after = count - {1'b0, pop};
  assign free        = 2'd2 - count_after;
  assign head        = slot0;

  // Shift out the popped item, then append pushed items behind the rest
  always_comb begin
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    if (count_after == 2'd0) begin
      slot0_next = push.r0;
      slot1_next = push.r1;
    end else if (count_after == 2'd1) begin
      slot1_next = push.r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_after + push.count;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

endmodule

`default_nettype wire

// ----- hdl/dictionary_entry_field_deframer.sv -----
// ----------------------------------------------------------------------------
// dictionary_entry_field_deframer: typed field splitter for dictionary entries
// Splits an entry, one byte per item, into typed fields from a stream-given
// or configured list of field types.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while in_stall is low. A byte is
// registered, decoded against the entry state in one pass and its results
// are written to a two-entry result queue, so the next byte is accepted
// while earlier results wait at the output. Type and length header bytes
// yield no result; content bytes and terminators yield one; in list mode a
// last byte that completes a field before the final listed one began yields
// two, and the input holds while the queue still has a result waiting that
// is not leaving. Sustained throughput, while the output is not stalled, is
// one byte per cycle, set by the single decode pass and the queue's single
// output port. Register writes are meant for idle periods between entries
// and take effect at the next field start.
`timescale 1ns / 1ps
`default_nettype none

module dictionary_entry_field_deframer
  import dedf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // Byte input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  // Result output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       field_type,
  output logic [7:0]       payload_byte,
  output logic             payload_valid,
  output logic             field_done,
  output logic [31:0]      field_bytes,
  output logic             error_flag,
  output logic             entry_done,
  output logic             last_result
);

  cfg_t       cfg;
  push_t      push;
  logic [1:0] free;
  result_t    head;

  dedf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dedf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .free      (free),
    .push      (push)
  );

  dedf_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // Drive the result fields from the queue head
  assign field_type    = head.field_type;
  assign payload_byte  = head.payload_byte;
  assign payload_valid = head.payload_valid;
  assign field_done    = head.field_done;
  assign field_bytes   = head.field_bytes;
  assign error_flag    = head.error_flag;
  assign entry_done    = head.entry_done;
  assign last_result   = head.last_result;

endmodule

`default_nettype wire

// ----- hdl/dedf_checker.sv -----
// ----------------------------------------------------------------------------
// dedf_checker: port-level checks for the entry field deframer
// Watches the result channel for consistent field flags and held items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dedf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  payload_byte,
  input wire logic        payload_valid,
  input wire logic        field_done,
  input wire logic [31:0] field_bytes,
  input wire logic        error_flag,
  input wire logic        entry_done,
  input wire logic        last_result
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Entry error and entry end come on the item's final result
  a_error_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> entry_done && last_result)
    else $error("error flag away from the final result of an entry");

  // Counts appear only on field completion, bytes only with their flag
  a_zero_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (field_done || field_bytes == 32'd0) &&
                  (payload_valid || payload_byte == 8'd0))
    else $error("unused result field not zero");

  // A stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(field_bytes) &&
                               $stable(payload_byte) && $stable(entry_done))
    else $error("stalled result item changed");

endmodule

bind dictionary_entry_field_deframer dedf_checker u_dedf_checker (.*);

`default_nettype wire

// ----- dv/dedf_field_checker.sv -----
// ----------------------------------------------------------------------------
// dedf_field_checker: result predictor and scoreboard for the field deframer
// Watches the configuration, byte and result channels at the rising edge,
// decodes every accepted byte against its own copy of the entry state and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dedf_field_checker
  import dedf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  field_type,
  input  logic [7:0]  payload_byte,
  input  logic        payload_valid,
  input  logic        field_done,
  input  logic [31:0] field_bytes,
  input  logic        error_flag,
  input  logic        entry_done,
  input  logic        last_result,
  output int          fail_count,
  output int          pending
);

  // Register copies
  logic        list_mode;
  logic [63:0] type_list;
  logic [3:0]  list_count;

  // Entry decode state
  phase_t      ph;
  logic [7:0]  cur_type;
  logic [1:0]  hdr_idx;
  logic [31:0] len_acc;
  logic [31:0] remaining;
  logic [31:0] content_cnt;
  logic [2:0]  list_idx;
  logic        err_seen;

  // Results of the byte being decoded, and those still awaited
  result_t     step_res [2];
  int          step_n;
  result_t     want_results [$];

  function automatic logic [2:0] final_slot();
    if (list_count == 4'd0) return 3'd0;
    if (list_count > 4'd8) return 3'd7;
    return 3'(list_count - 4'd1);
  endfunction

  function automatic logic [2:0] active_slot();
    return (list_idx > final_slot()) ? final_slot() : list_idx;
  endfunction

  function automatic logic [7:0] listed_type(input logic [2:0] idx);
    return type_list[idx * 8 +: 8];
  endfunction

  task automatic clear_entry();
    ph          = PH_TYPE;
    cur_type    = 8'd0;
    hdr_idx     = 2'd0;
    len_acc     = 32'd0;
    remaining   = 32'd0;
    content_cnt = 32'd0;
    list_idx    = 3'd0;
    err_seen    = 1'b0;
  endtask

  task automatic open_field(input logic [7:0] t, input logic last_field);
    cur_type    = t;
    hdr_idx     = 2'd0;
    len_acc     = 32'd0;
    remaining   = 32'd0;
    content_cnt = 32'd0;
    if (last_field) ph = PH_ALL;
    else if (t >= 8'h61 && t <= 8'h7a) ph = PH_TEXT;
    else ph = PH_LEN;
  endtask

  task automatic close_field();
    ph = PH_TYPE;
    if (list_idx < 3'd7) list_idx = list_idx + 3'd1;
  endtask

  task automatic count_byte();
    if (content_cnt != '1) content_cnt = content_cnt + 32'd1;
  endtask

  task automatic emit(input logic [7:0] t, input logic [7:0] b, input logic pv,
                      input logic fd, input logic [31:0] fb);
    step_res[step_n]               = '0;
    step_res[step_n].field_type    = t;
    step_res[step_n].payload_byte  = b;
    step_res[step_n].payload_valid = pv;
    step_res[step_n].field_done    = fd;
    step_res[step_n].field_bytes   = fb;
    step_n++;
  endtask

  // Decode one accepted byte and queue the results it should produce
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic       taken;
    logic [2:0] idx;
    taken  = 1'b0;
    step_n = 0;
    if (ph == PH_TYPE) begin
      if (list_mode) begin
        idx = active_slot();
        open_field(listed_type(idx), idx == final_slot());
      end else begin
        open_field(b, 1'b0);
        taken = 1'b1;
      end
    end
    if (!taken) begin
      case (ph)
        PH_TEXT: begin
          if (b == 8'h00) begin
            emit(cur_type, 8'h00, 1'b0, 1'b1, content_cnt);
            close_field();
          end else begin
            emit(cur_type, b, 1'b1, 1'b0, 32'd0);
            count_byte();
          end
        end
        PH_LEN: begin
          len_acc = {len_acc[23:0], b};
          hdr_idx = hdr_idx + 2'd1;
          if (hdr_idx == 2'd0) begin
            remaining = len_acc;
            if (remaining == 32'd0) begin
              emit(cur_type, 8'h00, 1'b0, 1'b1, 32'd0);
              close_field();
            end else begin
              ph = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          count_byte();
          remaining = remaining - 32'd1;
          if (remaining == 32'd0) begin
            emit(cur_type, b, 1'b1, 1'b1, content_cnt);
            close_field();
          end else begin
            emit(cur_type, b, 1'b1, 1'b0, 32'd0);
          end
        end
        default: begin
          count_byte();
          emit(cur_type, b, 1'b1, 1'b0, 32'd0);
        end
      endcase
    end
    // Close the entry: final field, empty trailing field or truncation
    if (lst) begin
      if (ph == PH_ALL) begin
        step_res[0].field_done  = 1'b1;
        step_res[0].field_bytes = content_cnt;
      end else if (ph == PH_TYPE) begin
        if (list_mode) begin
          idx = active_slot();
          if (idx == final_slot()) begin
            emit(listed_type(idx), 8'h00, 1'b0, 1'b1, 32'd0);
          end else begin
            err_seen = 1'b1;
            emit(listed_type(idx), 8'h00, 1'b0, 1'b0, 32'd0);
          end
        end
      end else begin
        err_seen = 1'b1;
      end
      if (step_n == 0) emit(cur_type, 8'h00, 1'b0, 1'b0, 32'd0);
      step_res[step_n - 1].error_flag = err_seen;
      step_res[step_n - 1].entry_done = 1'b1;
      clear_entry();
    end
    if (step_n > 0) step_res[step_n - 1].last_result = 1'b1;
    for (int k = 0; k < step_n; k++) want_results.push_back(step_res[k]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Track registers, predict on accepted bytes, compare accepted results
  always @(posedge clk) begin
    result_t w;
    if (rst) begin
      list_mode  = 1'b0;
      type_list  = 64'd0;
      list_count = 4'd1;
      clear_entry();
      want_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:  list_mode  = cfg_data[0];
          REG_TYPES: type_list  = cfg_data;
          REG_COUNT: list_count = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        if (want_results.size() == 0) begin
          $error("result with no prediction waiting: field_type %0h", field_type);
          fail_count++;
        end else begin
          w = want_results.pop_front();
          check_field("field_type", w.field_type, field_type);
          check_field("payload_byte", w.payload_byte, payload_byte);
          check_field("payload_valid", w.payload_valid, payload_valid);
          check_field("field_done", w.field_done, field_done);
          check_field("field_bytes", w.field_bytes, field_bytes);
          check_field("error_flag", w.error_flag, error_flag);
          check_field("entry_done", w.entry_done, entry_done);
          check_field("last_result", w.last_result, last_result);
        end
      end
    end
    pending = want_results.size();
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the dictionary entry field deframer
// Runs a short directed set of entries, then random well-formed, truncated
// and noise entries under several register settings in free and list mode,
// with random idling on the byte and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dedf_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MODE;
  logic [63:0] cfg_data = 64'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  field_type;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        field_done;
  logic [31:0] field_bytes;
  logic        error_flag;
  logic        entry_done;
  logic        last_result;
  int          fail_count;
  int          pending;

  // Stimulus-side copy of the registers and the entry being built
  logic        cur_mode = 1'b0;
  logic [3:0]  cur_count = 4'd1;
  logic [63:0] cur_types = 64'd0;
  logic [7:0]  entry_bytes [$];
  int          gap_pct = 36;
  int          bytes_sent = 0;

  dictionary_entry_field_deframer dut (.*);
  dedf_field_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < gap_pct);
  end

  // Drive one byte, idling first at random; return after it is taken
  task automatic push_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_entry();
    foreach (entry_bytes[i]) push_byte(entry_bytes[i], i == entry_bytes.size() - 1);
  endtask

  function automatic logic [7:0] rand_type();
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h61, 8'h7a));
    return 8'($urandom_range(0, 255));
  endfunction

  // Append a field body: zero-terminated text or length header and content
  task automatic add_body(input logic [7:0] t);
    int len;
    if (t >= 8'h61 && t <= 8'h7a) begin
      repeat ($urandom_range(0, 5)) entry_bytes.push_back(8'($urandom_range(1, 255)));
      entry_bytes.push_back(8'h00);
    end else begin
      len = ($urandom_range(0, 99) < 2) ? $urandom_range(256, 300) : $urandom_range(0, 5);
      for (int s = 24; s >= 0; s -= 8) entry_bytes.push_back(8'(len >> s));
      repeat (len) entry_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Build one random entry: mostly well formed, some truncated, some noise
  task automatic build_entry();
    int kind;
    int top;
    int done_fields;
    int cut;
    logic [7:0] t;
    entry_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) entry_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (!cur_mode) begin
      repeat ($urandom_range(1, 3)) begin
        t = rand_type();
        entry_bytes.push_back(t);
        add_body(t);
      end
    end else begin
      top = (cur_count == 4'd0) ? 0 : (cur_count > 4'd8) ? 7 : cur_count - 1;
      done_fields = $urandom_range(0, top);
      for (int i = 0; i < done_fields; i++) add_body(cur_types[i * 8 +: 8]);
      if (done_fields == top)
        repeat ($urandom_range(0, 6)) entry_bytes.push_back(8'($urandom_range(0, 255)));
      if (entry_bytes.size() == 0) entry_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // Cut some entries short
    if (kind >= 10 && kind < 25 && entry_bytes.size() > 1) begin
      cut = $urandom_range(1, entry_bytes.size() - 1);
      while (entry_bytes.size() > cut) void'(entry_bytes.pop_back());
    end
  endtask

  task automatic run_random(input int nbytes);
    int stop_at;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      build_entry();
      send_entry();
    end
    in_valid <= 1'b0;
  endtask

  // Wait until every predicted result is out and header bytes have drained
  task automatic drain();
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_reg(input reg_index_t idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_config(input logic mode, input logic [63:0] types,
                             input logic [3:0] cnt);
    cur_mode  = mode;
    cur_types = types;
    cur_count = cnt;
    put_reg(REG_MODE, {63'd0, mode});
    put_reg(REG_TYPES, types);
    put_reg(REG_COUNT, {60'd0, cnt});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_list();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[i * 8 +: 8] = rand_type();
    return v;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Free mode, reset settings: empty text, zero length, binary then text,
    // entry ending on a type byte, huge length cut short
    entry_bytes = '{8'h61, 8'h00};
    send_entry();
    entry_bytes = '{8'h42, 8'h00, 8'h00, 8'h00, 8'h00};
    send_entry();
    entry_bytes = '{8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h7a, 8'h41, 8'h00};
    send_entry();
    entry_bytes = '{8'h71};
    send_entry();
    entry_bytes = '{8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h5a};
    send_entry();
    run_random(40);
    drain();

    // List mode, text field then open-ended field; end early and mid-field
    load_config(1'b1, 64'h0000_0000_0000_4261, 4'd2);
    entry_bytes = '{8'h41, 8'h00};
    send_entry();
    entry_bytes = '{8'h41};
    send_entry();
    run_random(40);
    drain();

    load_config(1'b1, '1, 4'd15);
    run_random(40);
    drain();

    load_config(1'b1, 64'd0, 4'd0);
    run_random(40);
    drain();

    // No idling on either side for this stretch
    gap_pct = 0;
    load_config(1'b1, rand_list(), 4'd8);
    run_random(40);
    drain();
    gap_pct = 36;

    load_config(1'b0, rand_list(), 4'd1);
    run_random(40);
    drain();

    load_config(1'b1, rand_list(), 4'($urandom_range(1, 7)));
    run_random(40);

    wait (pending == 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
